[rtl/mbd_pkg.sv]
// shared types and constants of the multi-button debouncer
package mbd_pkg;

  localparam int LEVEL_W   = 7;
  localparam int FACTOR_W  = 8;
  localparam int NUM_W     = 16;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int INDEX_W   = 3;
  localparam int MASK_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(100);

  localparam logic [REG_IDX_W-1:0] REG_FACTOR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

[rtl/mbd_ram.sv]
// generic single-write, single-read ram with registered read data
module mbd_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mbd_div.sv]
// iterative restoring divider, two quotient bits per cycle
module mbd_div
  import mbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    dividend_i,
  input  logic [FACTOR_W-1:0] divisor_i,
  output logic                done_o,
  output logic [LEVEL_W-1:0]  quotient_o
);

  logic [NUM_W-1:0]    dvd_q, dvd_d;
  logic [FACTOR_W-1:0] rem_q, rem_d;
  logic [FACTOR_W-1:0] dsr_q;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [FACTOR_W:0]   r1, r1s, r2, r2s;
  logic                ge1, ge2;

  always_comb begin
    r1  = {rem_q, dvd_q[NUM_W-1]};
    ge1 = r1 >= {1'b0, dsr_q};
    r1s = ge1 ? r1 - {1'b0, dsr_q} : r1;
    r2  = {r1s[FACTOR_W-1:0], dvd_q[NUM_W-2]};
    ge2 = r2 >= {1'b0, dsr_q};
    r2s = ge2 ? r2 - {1'b0, dsr_q} : r2;
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NUM_W-3:0], ge1, ge2};
      rem_d = r2s[FACTOR_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[LEVEL_W-1:0];

endmodule

[rtl/multi_button_ema_debouncer.sv]
// top level of the multi-button exponential-average debouncer
// Each accepted beat is one raw pin sample of one button. The block updates that
// button's filtered level (0 to 100) as floor((old*(factor-1) + raw*100)/factor)
// and its debounced pressed flag with hysteresis between the low and high
// thresholds, then delivers one result beat; samples for an index not below
// BUTTONS give no result. A button's first sample starts from its released level.
// Each sample passes in order through a load step that forms the numerator from
// the level-table read, the shared divider (two quotient bits per cycle), a step
// in which the divider reports done, a commit step and an idle step that takes
// the next sample.
// in_stall_o is high from the load step through the commit step.
// The result sits in an output register, so a stalled result does not hold up
// the next sample until that sample is ready to commit.
module multi_button_ema_debouncer
  import mbd_pkg::*;
#(
  parameter int BUTTONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [INDEX_W-1:0]  button_index_i,
  input  logic                raw_level_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [INDEX_W-1:0]  button_echo_o,
  output logic                press_event_o,
  output logic                now_pressed_o,
  output logic                was_held_o,
  output logic [LEVEL_W-1:0]  filtered_level_o
);

  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic [FACTOR_W-1:0] factor_q;
  logic [LEVEL_W-1:0]  low_q;
  logic [LEVEL_W-1:0]  high_q;
  logic [MASK_W-1:0]   mask_q;

  state_e state_q, state_d;

  logic [IDX_W-1:0]    idx_q;
  logic [INDEX_W-1:0]  echo_q;
  logic                raw_q;
  logic [BUTTONS-1:0]  seen_q, pressed_q;

  logic                out_valid_q;
  logic [INDEX_W-1:0]  echo_out_q;
  logic                press_q, now_q, held_q;
  logic [LEVEL_W-1:0]  level_out_q;

  logic                accept, cfg_wr, out_free, commit, load_en;
  logic                in_range, active_high;
  logic [FACTOR_W-1:0] factor_eff, factor_m1;
  logic [LEVEL_W-1:0]  old_level, rd_level, new_level;
  logic [NUM_W-1:0]    numerator;
  logic                div_done;
  logic                was_pressed, after;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_W'(4);
      low_q    <= LEVEL_W'(30);
      high_q   <= LEVEL_W'(70);
      mask_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_W+1:2])
        REG_FACTOR: factor_q <= pwdata[FACTOR_W-1:0];
        REG_LOW:    low_q    <= pwdata[LEVEL_W-1:0];
        REG_HIGH:   high_q   <= pwdata[LEVEL_W-1:0];
        REG_MASK:   mask_q   <= pwdata[MASK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_W+1:2])
      REG_FACTOR: prdata = DATA_W'(factor_q);
      REG_LOW:    prdata = DATA_W'(low_q);
      REG_HIGH:   prdata = DATA_W'(high_q);
      REG_MASK:   prdata = DATA_W'(mask_q);
      default:    prdata = '0;
    endcase
  end

  // sequencer
  assign in_range = 32'(button_index_i) < BUTTONS;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && in_range) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_en    = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_LOAD: load_en    = 1'b1;
      ST_DIV:  ;
      ST_DONE: commit     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= IDX_W'(button_index_i);
      echo_q <= button_index_i;
      raw_q  <= raw_level_i;
    end
  end

  // level table
  mbd_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(BUTTONS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (idx_q),
    .wdata_i (new_level),
    .re_i    (accept),
    .raddr_i (IDX_W'(button_index_i)),
    .rdata_o (rd_level)
  );

  // numerator and shared divider
  assign active_high = mask_q[echo_q];
  assign factor_eff  = (factor_q == '0) ? FACTOR_W'(1) : factor_q;
  assign factor_m1   = factor_eff - FACTOR_W'(1);
  assign old_level   = seen_q[idx_q] ? rd_level : (active_high ? '0 : FULL_LEVEL);
  assign numerator   = NUM_W'(old_level) * NUM_W'(factor_m1)
                     + (raw_q ? NUM_W'(FULL_LEVEL) : '0);

  mbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (load_en),
    .dividend_i (numerator),
    .divisor_i  (factor_eff),
    .done_o     (div_done),
    .quotient_o (new_level)
  );

  // hysteresis
  always_comb begin
    was_pressed = pressed_q[idx_q];
    after       = was_pressed;
    if (!was_pressed) begin
      if (active_high ? (new_level > high_q) : (new_level < low_q)) after = 1'b1;
    end else begin
      if (active_high ? (new_level < low_q) : (new_level > high_q)) after = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      pressed_q <= '0;
    end else if (commit) begin
      seen_q[idx_q]    <= 1'b1;
      pressed_q[idx_q] <= after;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      echo_out_q  <= echo_q;
      press_q     <= !was_pressed && after;
      now_q       <= after;
      held_q      <= was_pressed;
      level_out_q <= new_level;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign button_echo_o    = echo_out_q;
  assign press_event_o    = press_q;
  assign now_pressed_o    = now_q;
  assign was_held_o       = held_q;
  assign filtered_level_o = level_out_q;

endmodule
